// ----- rtl/core/xed_pkg.sv -----
package xed_pkg;

    localparam int MAX_OUT = 6;

    typedef logic [7:0] byte_t;

    // One accepted input item turns into at most one command: up to six bytes to send.
    typedef struct packed {
        byte_t [MAX_OUT-1:0] bytes;
        logic [2:0]          cnt;
        logic                has_byte;
        logic                last;
    } cmd_t;

    typedef struct packed {
        byte_t [3:0] bytes;
        logic [2:0]  cnt;
    } utf8_t;

    localparam logic [20:0] CODE_MAX = 21'h10FFFF;
    localparam byte_t LEAD2 = 8'hC0;
    localparam byte_t LEAD3 = 8'hE0;
    localparam byte_t LEAD4 = 8'hF0;
    localparam byte_t CONT  = 8'h80;
    localparam byte_t CONT_MASK = 8'h3F;

    localparam byte_t CH_AMP  = 8'h26;
    localparam byte_t CH_HASH = 8'h23;
    localparam byte_t CH_SEMI = 8'h3B;
    localparam byte_t CH_X    = 8'h78;

    localparam int NUM_ENT = 5;

    localparam byte_t ENT_TEXT [NUM_ENT][5] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
    localparam byte_t ENT_CHAR [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    // Returns {valid, value} for a digit in the current radix.
    function automatic logic [4:0] digit_of(byte_t b, logic hex);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (hex && b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h61 + 8'd10)};
        else if (hex && b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h41 + 8'd10)};
        return r;
    endfunction

    // UTF-8 bytes of a code point; zero, overflowed or out of range gives none.
    function automatic utf8_t utf8_encode(logic [20:0] c, logic ovf);
        utf8_t u;
        u = '0;
        if (ovf || c == 21'd0 || c > CODE_MAX)
            u.cnt = 3'd0;
        else if (c < 21'h80) begin
            u.cnt = 3'd1;
            u.bytes[0] = c[7:0];
        end
        else if (c < 21'h800) begin
            u.cnt = 3'd2;
            u.bytes[0] = LEAD2 | {3'd0, c[10:6]};
            u.bytes[1] = CONT | ({2'd0, c[5:0]} & CONT_MASK);
        end
        else if (c < 21'h10000) begin
            u.cnt = 3'd3;
            u.bytes[0] = LEAD3 | {4'd0, c[15:12]};
            u.bytes[1] = CONT | ({2'd0, c[11:6]} & CONT_MASK);
            u.bytes[2] = CONT | ({2'd0, c[5:0]} & CONT_MASK);
        end
        else begin
            u.cnt = 3'd4;
            u.bytes[0] = LEAD4 | {5'd0, c[20:18]};
            u.bytes[1] = CONT | ({2'd0, c[17:12]} & CONT_MASK);
            u.bytes[2] = CONT | ({2'd0, c[11:6]} & CONT_MASK);
            u.bytes[3] = CONT | ({2'd0, c[5:0]} & CONT_MASK);
        end
        return u;
    endfunction

endpackage

// ----- rtl/core/xed_front.sv -----
module xed_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xed_pkg::byte_t     in_byte,
    input  logic               in_last,
    input  logic               q_space,
    output logic               push,
    output xed_pkg::cmd_t      cmd
);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NAME   = 3'd1;
    localparam logic [2:0] MODE_HASH   = 3'd2;
    localparam logic [2:0] MODE_DIGITS = 3'd3;
    localparam logic [2:0] MODE_SKIP   = 3'd4;

    logic [2:0]     mode_reg, mode_next;
    xed_pkg::byte_t held_reg [4];
    xed_pkg::byte_t held_next [4];
    logic [2:0]     hcnt_reg, hcnt_next;
    logic [20:0]    cv_reg, cv_next;
    logic           ovf_reg, ovf_next;
    logic           hex_reg, hex_next;

    xed_pkg::byte_t [xed_pkg::MAX_OUT-1:0] ob;
    logic [2:0]     on;
    logic           has_byte;
    logic           do_dig;
    logic           hit;
    logic [2:0]     hit_k;
    logic           ok;
    logic [4:0]     dig;
    logic [24:0]    v;
    xed_pkg::utf8_t u_semi;
    xed_pkg::utf8_t u_end;
    logic           accept;

    assign in_ready = q_space;
    assign accept   = in_valid && q_space;

    // Which entity, if any, the held letters plus this byte still spell.
    always_comb
    begin
        hit   = 1'b0;
        hit_k = 3'd0;
        for (int k = 0; k < xed_pkg::NUM_ENT; k++)
        begin
            ok = hcnt_reg < xed_pkg::ENT_LEN[k];
            for (int i = 0; i < 4; i++)
            begin
                if (3'(i) < hcnt_reg && xed_pkg::ENT_TEXT[k][i] != held_reg[i])
                    ok = 1'b0;
            end
            if (ok && !hit && xed_pkg::ENT_TEXT[k][hcnt_reg] == in_byte)
            begin
                hit   = 1'b1;
                hit_k = 3'(k);
            end
        end
    end

    assign dig = xed_pkg::digit_of(in_byte, hex_reg);
    assign v = hex_reg ? ({4'd0, cv_reg} << 4) + {21'd0, dig[3:0]}
                       : ({4'd0, cv_reg} << 3) + ({4'd0, cv_reg} << 1) + {21'd0, dig[3:0]};
    assign u_semi = xed_pkg::utf8_encode(cv_reg, ovf_reg);

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        cv_next   = cv_reg;
        ovf_next  = ovf_reg;
        hex_next  = hex_reg;
        ob        = '0;
        on        = 3'd0;
        has_byte  = 1'b1;
        do_dig    = 1'b0;
        u_end     = '0;

        unique case (mode_reg)
            MODE_NAME:
            begin
                if (hcnt_reg == 3'd0 && in_byte == xed_pkg::CH_HASH)
                begin
                    mode_next = MODE_HASH;
                    cv_next   = '0;
                    ovf_next  = 1'b0;
                    hex_next  = 1'b0;
                end
                else if (hit)
                begin
                    if (hcnt_reg + 3'd1 == xed_pkg::ENT_LEN[hit_k])
                    begin
                        ob[on] = xed_pkg::ENT_CHAR[hit_k];
                        on = on + 3'd1;
                        mode_next = MODE_IDLE;
                        hcnt_next = 3'd0;
                        cv_next   = '0;
                        ovf_next  = 1'b0;
                        hex_next  = 1'b0;
                    end
                    else
                    begin
                        held_next[hcnt_reg[1:0]] = in_byte;
                        hcnt_next = hcnt_reg + 3'd1;
                    end
                end
                else
                begin
                    // Broken match: send the ampersand and the held letters, then treat this byte
                    // as plain text, or as the start of a new entity if it is an ampersand.
                    ob[on] = xed_pkg::CH_AMP;
                    on = on + 3'd1;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < hcnt_reg)
                        begin
                            ob[on] = held_reg[i];
                            on = on + 3'd1;
                        end
                    end
                    hcnt_next = 3'd0;
                    if (in_byte == xed_pkg::CH_AMP)
                        mode_next = MODE_NAME;
                    else
                    begin
                        mode_next = MODE_IDLE;
                        ob[on] = in_byte;
                        on = on + 3'd1;
                    end
                end
            end
            MODE_HASH:
            begin
                mode_next = MODE_DIGITS;
                if (in_byte == xed_pkg::CH_X)
                    hex_next = 1'b1;
                else
                    do_dig = 1'b1;
            end
            MODE_DIGITS:
            begin
                do_dig = 1'b1;
            end
            MODE_SKIP:
            begin
                if (in_byte == xed_pkg::CH_SEMI)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < u_semi.cnt)
                        begin
                            ob[on] = u_semi.bytes[i];
                            on = on + 3'd1;
                        end
                    end
                    mode_next = MODE_IDLE;
                    hcnt_next = 3'd0;
                    cv_next   = '0;
                    ovf_next  = 1'b0;
                    hex_next  = 1'b0;
                end
            end
            default:
            begin
                if (in_byte == xed_pkg::CH_AMP)
                begin
                    mode_next = MODE_NAME;
                    hcnt_next = 3'd0;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    ob[on] = in_byte;
                    on = on + 3'd1;
                end
            end
        endcase

        if (do_dig)
        begin
            if (in_byte == xed_pkg::CH_SEMI)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < u_semi.cnt)
                    begin
                        ob[on] = u_semi.bytes[i];
                        on = on + 3'd1;
                    end
                end
                mode_next = MODE_IDLE;
                hcnt_next = 3'd0;
                cv_next   = '0;
                ovf_next  = 1'b0;
                hex_next  = 1'b0;
            end
            else if (!dig[4])
                mode_next = MODE_SKIP;
            else if (!ovf_reg)
            begin
                if (v > {4'd0, xed_pkg::CODE_MAX})
                    ovf_next = 1'b1;
                else
                    cv_next = v[20:0];
            end
        end

        if (in_last)
        begin
            if (mode_next == MODE_NAME)
            begin
                ob[on] = xed_pkg::CH_AMP;
                on = on + 3'd1;
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < hcnt_next)
                    begin
                        ob[on] = held_next[i];
                        on = on + 3'd1;
                    end
                end
            end
            else if (mode_next == MODE_HASH || mode_next == MODE_DIGITS ||
                     mode_next == MODE_SKIP)
            begin
                // The value includes any digit taken with this byte.
                u_end = xed_pkg::utf8_encode(cv_next, ovf_next);
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < u_end.cnt)
                    begin
                        ob[on] = u_end.bytes[i];
                        on = on + 3'd1;
                    end
                end
            end
            mode_next = MODE_IDLE;
            hcnt_next = 3'd0;
            cv_next   = '0;
            ovf_next  = 1'b0;
            hex_next  = 1'b0;
            if (on == 3'd0)
            begin
                // End marker with no byte.
                has_byte = 1'b0;
                on = 3'd1;
            end
        end
    end

    assign push         = accept && (on != 3'd0);
    assign cmd.bytes    = ob;
    assign cmd.cnt      = on;
    assign cmd.has_byte = has_byte;
    assign cmd.last     = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hcnt_reg <= 3'd0;
            cv_reg   <= '0;
            ovf_reg  <= 1'b0;
            hex_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hcnt_reg <= hcnt_next;
            cv_reg   <= cv_next;
            ovf_reg  <= ovf_next;
            hex_reg  <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

// ----- rtl/core/xed_queue.sv -----
module xed_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xed_pkg::cmd_t push_cmd,
    output logic          space,
    input  logic          pop,
    output logic          head_valid,
    output xed_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xed_pkg::cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign space      = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/core/xed_back.sv -----
module xed_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  xed_pkg::cmd_t  head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output xed_pkg::byte_t out_byte,
    output logic           out_has_byte,
    output logic           out_last
);

    logic [2:0]     idx_reg;
    logic           valid_reg;
    xed_pkg::byte_t byte_reg;
    logic           has_reg;
    logic           last_reg;
    logic           load;
    logic           final_byte;

    assign load       = head_valid && (!valid_reg || out_ready);
    assign final_byte = idx_reg == head_cmd.cnt - 3'd1;
    assign pop        = load && final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_byte ? 3'd0 : idx_reg + 3'd1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head_cmd.bytes[idx_reg];
            has_reg  <= head_cmd.has_byte;
            last_reg <= head_cmd.last && final_byte;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_has_byte = has_reg;
    assign out_last     = last_reg;

endmodule

// ----- rtl/core/xml_entity_to_utf8_decoder.sv -----
// XML character reference decoder with UTF-8 output.
// The slave channel takes one text byte per item (s_tdata) and s_tlast on the
// final byte of the text. The master channel gives one decoded byte per item
// on m_tdata, with m_tuser high when the item carries a byte and m_tlast on
// the final item of the text. An item with m_tuser low is an end marker,
// sent only when the final input byte produced nothing else.
// A front stage classifies each accepted byte against the entity state and
// turns it into a command of zero to six bytes; a command queue of
// QUEUE_DEPTH entries feeds a back stage that sends the bytes one a cycle while the receiver is ready.
// The first output byte passes through the queue entry and then the output register before it is presented.
// Throughput is one input byte per cycle as long as commands carry one byte and the receiver is ready;
// a command with several bytes holds the output while its bytes go out one by one, and the queue
// absorbs these bursts until it fills, at which point s_tready drops.
// When the receiver stalls, the output register holds its item and the
// queue keeps filling; input is refused only when the queue is full.
// Reset clears the entity state, the queue and the output valid flag; the
// held letters need no reset since they are written before being read.
module xml_entity_to_utf8_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] has_byte
    output logic       m_tlast
);

    logic          push;
    logic          pop;
    logic          q_space;
    logic          head_valid;
    xed_pkg::cmd_t push_cmd;
    xed_pkg::cmd_t head_cmd;

    // Front: entity scanner and command builder.
    xed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_space  (q_space),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Queue of commands between the two halves.
    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: serializes each command into output items.
    xed_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_has_byte (m_tuser),
        .out_last     (m_tlast)
    );

    // An end marker only ever closes the text.
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("end marker without last flag");

    // Every command in the queue carries between one and six bytes.
    a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> head_cmd.cnt != 3'd0 && head_cmd.cnt <= 3'd6)
        else $error("queued command with bad byte count");

    // The final input byte always produces a command.
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> push && push_cmd.last)
        else $error("final byte produced no command");

endmodule

// ----- dv/tb_xml_entity_to_utf8_decoder.sv -----
`timescale 1ns / 100ps

module tb_xml_entity_to_utf8_decoder;

    typedef xed_pkg::byte_t byte_t;
    localparam int MAX_OUT = xed_pkg::MAX_OUT;

    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    // Scan states of the decoder, as the predictor tracks them.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NAME,
        SCAN_HASH,
        SCAN_DIGITS,
        SCAN_SKIP
    } scan_t;

    // One decoded output item, as it is expected on the master side.
    typedef struct packed {
        byte_t data;
        logic  has;
        logic  last;
    } out_item_t;

    // Named entities: spelling after the '&', its length and the character it stands for.
    localparam byte_t SPELL_TBL [5][5] = '{
        '{"a", "m", "p", ";", 8'h00},
        '{"l", "t", ";", 8'h00, 8'h00},
        '{"g", "t", ";", 8'h00, 8'h00},
        '{"q", "u", "o", "t", ";"},
        '{"a", "p", "o", "s", ";"}
    };
    localparam int SPELL_LEN [5] = '{4, 3, 3, 5, 5};
    localparam byte_t SPELL_CHAR [5] = '{"&", "<", ">", 8'h22, 8'h27};
    localparam int CODE_LIMIT = 32'h10FFFF;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Predictor state.
    scan_t       scan_mode;
    byte_t       held [4];
    int          held_n;
    logic [20:0] cp_value;
    logic        cp_ovf;
    logic        cp_hex;

    out_item_t   burst [$];         // results of the input byte being predicted
    out_item_t   pending_out [$];   // decoded items still owed by the block
    byte_t       text_bytes [$];    // text being built for the sender
    int          items_sent;
    int          mismatches;
    int          quiet_cycles;
    int          sink_hold;
    bit          gaps_on;

    xml_entity_to_utf8_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tuser  (m_tuser),    // [0] has_byte
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_scan();
        scan_mode = SCAN_IDLE;
        held_n    = 0;
        cp_value  = '0;
        cp_ovf    = 1'b0;
        cp_hex    = 1'b0;
    endfunction

    function automatic void put_byte(byte_t b);
        out_item_t o;
        o = {b, 1'b1, 1'b0};
        if (burst.size() < MAX_OUT)
            burst = {burst, o};
    endfunction

    // Index of the entity that the held letters followed by b still spell, or -1.
    function automatic int match_entity(byte_t b);
        bit ok;
        for (int k = 0; k < 5; k++)
        begin
            if (held_n < SPELL_LEN[k])
            begin
                ok = 1'b1;
                for (int i = 0; i < held_n; i++)
                    if (SPELL_TBL[k][i] != held[i])
                        ok = 1'b0;
                if (ok && SPELL_TBL[k][held_n] == b)
                    return k;
            end
        end
        return -1;
    endfunction

    // A broken or unfinished entity gives back the '&' and every held letter.
    function automatic void flush_amp();
        put_byte("&");
        for (int i = 0; i < held_n; i++)
            put_byte(held[i]);
        held_n = 0;
    endfunction

    function automatic void emit_utf8();
        logic [20:0] c;
        c = cp_value;
        if (cp_ovf || c == 21'd0 || c > CODE_LIMIT)
            return;
        if (c < 21'h80)
            put_byte(c[7:0]);
        else if (c < 21'h800)
        begin
            put_byte({3'b110, c[10:6]});
            put_byte({2'b10, c[5:0]});
        end
        else if (c < 21'h10000)
        begin
            put_byte({4'b1110, c[15:12]});
            put_byte({2'b10, c[11:6]});
            put_byte({2'b10, c[5:0]});
        end
        else
        begin
            put_byte({5'b11110, c[20:18]});
            put_byte({2'b10, c[17:12]});
            put_byte({2'b10, c[11:6]});
            put_byte({2'b10, c[5:0]});
        end
    endfunction

    function automatic int digit_val(byte_t b);
        if (b >= "0" && b <= "9")
            return b - "0";
        if (cp_hex && b >= "a" && b <= "f")
            return b - "a" + 10;
        if (cp_hex && b >= "A" && b <= "F")
            return b - "A" + 10;
        return -1;
    endfunction

    // ';' ends the reference, a non-digit skips, a digit adds; overflow is sticky.
    function automatic void digit_step(byte_t b);
        int d;
        int v;
        if (b == ";")
        begin
            emit_utf8();
            clear_scan();
            return;
        end
        d = digit_val(b);
        if (d < 0)
            scan_mode = SCAN_SKIP;
        else if (!cp_ovf)
        begin
            v = int'(cp_value) * (cp_hex ? 16 : 10) + d;
            if (v > CODE_LIMIT)
                cp_ovf = 1'b1;
            else
                cp_value = v[20:0];
        end
    endfunction

    function automatic void idle_byte(byte_t b);
        if (b == "&")
        begin
            scan_mode = SCAN_NAME;
            held_n    = 0;
        end
        else
            put_byte(b);
    endfunction

    // Works out the items that one accepted text byte causes and queues them.
    function automatic void decode_byte(byte_t b, logic last);
        int        k;
        out_item_t o;
        burst.delete();
        case (scan_mode)
            SCAN_NAME:
            begin
                if (held_n == 0 && b == "#")
                begin
                    scan_mode = SCAN_HASH;
                    cp_value  = '0;
                    cp_ovf    = 1'b0;
                    cp_hex    = 1'b0;
                end
                else
                begin
                    k = match_entity(b);
                    if (k >= 0)
                    begin
                        if (held_n + 1 == SPELL_LEN[k])
                        begin
                            put_byte(SPELL_CHAR[k]);
                            clear_scan();
                        end
                        else if (held_n < 4)
                        begin
                            held[held_n] = b;
                            held_n++;
                        end
                    end
                    else
                    begin
                        // The breaking byte is handled afresh, so it may start a new '&'.
                        flush_amp();
                        scan_mode = SCAN_IDLE;
                        idle_byte(b);
                    end
                end
            end
            SCAN_HASH:
            begin
                scan_mode = SCAN_DIGITS;
                if (b == "x")
                    cp_hex = 1'b1;
                else
                    digit_step(b);
            end
            SCAN_DIGITS:
                digit_step(b);
            SCAN_SKIP:
            begin
                if (b == ";")
                begin
                    emit_utf8();
                    clear_scan();
                end
            end
            default:
            begin
                scan_mode = SCAN_IDLE;
                idle_byte(b);
            end
        endcase

        // End of text closes whatever is open; an empty ending still gives a marker.
        if (last)
        begin
            if (scan_mode == SCAN_NAME)
                flush_amp();
            else if (scan_mode != SCAN_IDLE)
                emit_utf8();
            clear_scan();
            if (burst.size() == 0)
            begin
                o = '0;
                burst = {burst, o};
            end
            o = burst[burst.size() - 1];
            o.last = 1'b1;
            burst[burst.size() - 1] = o;
        end

        pending_out = {pending_out, burst};
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : out_check
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_out.size() == 0)
                report_mismatch("item with nothing pending, out_byte", m_tdata, 0);
            else
            begin
                want = pending_out.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", m_tdata, want.data);
                if (m_tuser !== want.has)
                    report_mismatch("has_byte", m_tuser, want.has);
                if (m_tlast !== want.last)
                    report_mismatch("out_last", m_tlast, want.last);
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: ready with random stalls while gaps are enabled.
    initial
    begin
        m_tready <= 1'b0;
        sink_hold = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                sink_hold = pick_gap();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offers one text byte, waits for it to be taken, then predicts its results.
    task automatic send_text_byte(byte_t b, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, last);
        items_sent++;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_text_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    function automatic void add_text_byte(byte_t b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_text_byte(s.getc(i));
    endfunction

    // Stops offering items and waits until every predicted item has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_out.size() != 0);
    endtask

    // Builds a random text from fragments: named entities, numeric references,
    // plain bytes and stray ampersands, some of them broken or cut off.
    task automatic make_text();
        int frags;
        int kind;
        int k;
        int cut;
        int cls;
        int v;
        int base;
        int lead;
        int tail;
        int n;
        bit hex;
        bit upper;
        int digs [$];
        text_bytes.delete();
        frags = $urandom_range(1, 6);
        repeat (frags)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                k   = $urandom_range(0, 4);
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SPELL_LEN[k] - 1)
                                                  : SPELL_LEN[k];
                add_text_byte("&");
                for (int i = 0; i < cut; i++)
                    add_text_byte(SPELL_TBL[k][i]);
                if (cut < SPELL_LEN[k])
                begin
                    case ($urandom_range(0, 2))
                        0:       add_text_byte("&");
                        1:       add_text_byte(SPELL_TBL[$urandom_range(0, 4)][0]);
                        default: add_text_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            else if (kind < 7)
            begin
                cls = $urandom_range(0, 9);
                case (cls)
                    0:       v = $urandom_range(1, 127);
                    1:       v = $urandom_range(128, 2047);
                    2:       v = $urandom_range(2048, 65535);
                    3:       v = $urandom_range(16'hD800, 16'hDFFF);
                    4:       v = $urandom_range(65536, CODE_LIMIT);
                    5:       v = $urandom_range(0, 1) ? CODE_LIMIT : 0;
                    6:       v = $urandom_range(CODE_LIMIT + 1, 32'h0FFF_FFFF);
                    default: v = $urandom_range(1, CODE_LIMIT);
                endcase
                hex   = $urandom_range(0, 1);
                upper = $urandom_range(0, 1);
                base  = hex ? 16 : 10;
                add_text_byte("&");
                add_text_byte("#");
                if (hex)
                    add_text_byte(($urandom_range(0, 7) == 0) ? "X" : "x");
                // The last class leaves the reference without any digits.
                if (cls != 9)
                begin
                    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                    repeat (lead) add_text_byte("0");
                    digs.delete();
                    do
                    begin
                        digs.push_front(v % base);
                        v = v / base;
                    end
                    while (v > 0);
                    foreach (digs[i])
                        add_text_byte((digs[i] < 10) ? 8'("0" + digs[i])
                                      : 8'((upper ? "A" : "a") + digs[i] - 10));
                end
                tail = $urandom_range(0, 9);
                if (tail >= 7 && tail < 9)
                    add_text_byte(8'($urandom_range(0, 255)));
                if (tail < 9)
                    add_text_byte(";");
            end
            else if (kind < 9)
            begin
                n = $urandom_range(1, 6);
                repeat (n) add_text_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_text_byte("&");
                n = $urandom_range(0, 3);
                repeat (n) add_text_byte(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
        // Sometimes the text ends in the middle of an entity or reference.
        if (text_bytes.size() > 2 && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n) text_bytes = text_bytes[0:$-1];
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        gaps_on = 1'b0;
        // Extreme byte values pass straight through.
        text_bytes = {8'h00, 8'hFF};
        send_text();
        text_bytes.delete();
        push_text("&lt;");
        send_text();
        // Uppercase X is not a hex marker, so only an end marker is produced.
        text_bytes.delete();
        push_text("&#X9;");
        send_text();
        // A surrogate code point still encodes as three bytes.
        text_bytes.delete();
        push_text("&#xD800;");
        send_text();
        // Too large a value, cut off by the end of text: only an end marker comes.
        text_bytes.delete();
        push_text("&#x110000");
        send_text();
        // End of text inside a named entity gives back the '&' and the letters.
        text_bytes.delete();
        push_text("&qu");
        send_text();
    endtask

    task automatic test_random_text(int budget);
        int goal;
        gaps_on = 1'b1;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            make_text();
            send_text();
        end
    endtask

    task automatic test_full_rate(int budget);
        int goal;
        gaps_on = 1'b0;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            make_text();
            send_text();
        end
    endtask

    // Sends bursts; the block drains fully after the first and after some later ones.
    task automatic test_drain_pause(int budget);
        int goal;
        bit drained;
        gaps_on = 1'b1;
        drained = 1'b0;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            make_text();
            send_text();
            if (!drained || $urandom_range(0, 2) == 0)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        gaps_on      = 1'b0;
        items_sent   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        clear_scan();
        foreach (held[i])
            held[i] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_text(240);
        test_full_rate(70);
        test_drain_pause(70);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
